[hw/rtl/mcx_pkg.sv]
// ----------------------------------------------------------------------------
// mcx_pkg
// shared constants and types of the circle raster framebuffer
// ----------------------------------------------------------------------------
package mcx_pkg;

  localparam int unsigned MEM_BYTES = 8192;
  localparam int unsigned MEM_AW    = $clog2(MEM_BYTES);
  localparam int unsigned FA_W      = 17;
  localparam logic [FA_W-1:0] MEM_LIMIT = FA_W'(MEM_BYTES);

  localparam int unsigned CRD_W  = 8;
  localparam int unsigned RAD_W  = 6;
  localparam int unsigned REG_W  = 9;
  localparam int unsigned BADR_W = 13;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    MODE_PIXEL  = 2'd0,
    MODE_CIRCLE = 2'd1,
    MODE_WRITE  = 2'd2,
    MODE_READ   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_PLOT  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  typedef struct packed {
    req_e              kind;
    logic [CRD_W-1:0]  x;
    logic [CRD_W-1:0]  y;
    logic              color;
    logic [BADR_W-1:0] addr;
    logic [7:0]        data;
  } fb_req_t;

  typedef struct packed {
    logic             pt_valid;
    logic [CRD_W-1:0] x;
    logic [CRD_W-1:0] y;
    logic             done;
  } circ_out_t;

endpackage

[hw/rtl/midpoint_circle_xor_raster.sv]
// ----------------------------------------------------------------------------
// midpoint_circle_xor_raster
// monochrome framebuffer with pixel, circle and byte access commands
// ----------------------------------------------------------------------------
// pixel, byte write and byte read: EXEC, then WAIT, then DONE registers the result
// circle: four axis points, then eight per loop step, about 0.71 * r loop steps,
//   one pixel read-modify-write per cycle, bar update steps, on the single framebuffer port
// one command at a time; s_axis_tready returns once the result is registered
// reset clears control state and sets width 128, height 64; framebuffer holds
//   garbage until written
module midpoint_circle_xor_raster import mcx_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [47:0]      s_axis_tdata,  // pos_x, pos_y, radius, color, byte_address, byte_data
  input  logic [1:0]       s_axis_tuser,  // mode
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // read_data, pixel_dropped, address_bad
  input  logic             cfg_we_i,
  input  logic             cfg_index_i,
  input  logic [REG_W-1:0] cfg_data_i
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_CIRC = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]        state_q, state_d;
  mode_e             mode_q;
  logic [CRD_W-1:0]  x_q, y_q;
  logic [RAD_W-1:0]  r_q;
  logic              color_q;
  logic [BADR_W-1:0] addr_q;
  logic [7:0]        data_q;
  logic [7:0]        res_rd_q;
  logic              res_drop_q, res_bad_q;
  logic              m_valid_q;
  logic [15:0]       m_data_q;
  logic [REG_W-1:0]  width_q, height_q;

  logic      s_beat, out_load, gen_start;
  fb_req_t   req;
  circ_out_t circ;
  logic      fb_drop, fb_bad;
  logic [7:0] fb_rdata;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_beat        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);
  assign gen_start     = (state_q == ST_EXEC) && (mode_q == MODE_CIRCLE);

  always_comb begin
    req.kind  = REQ_NONE;
    req.x     = x_q;
    req.y     = y_q;
    req.color = color_q;
    req.addr  = addr_q;
    req.data  = data_q;
    if (state_q == ST_EXEC) begin
      unique case (mode_q)
        MODE_PIXEL:  req.kind = REQ_PLOT;
        MODE_WRITE:  req.kind = REQ_WRITE;
        MODE_READ:   req.kind = REQ_READ;
        default:     req.kind = REQ_NONE;
      endcase
    end else if (state_q == ST_CIRC && circ.pt_valid) begin
      req.kind = REQ_PLOT;
      req.x    = circ.x;
      req.y    = circ.y;
    end
  end

  mcx_circle_gen u_gen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gen_start),
    .cx_i    (x_q),
    .cy_i    (y_q),
    .r_i     (r_q),
    .out_o   (circ)
  );

  mcx_fb_rmw u_fb (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .width_i  (width_q),
    .height_i (height_q),
    .drop_o   (fb_drop),
    .bad_o    (fb_bad),
    .rdata_o  (fb_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_beat) state_d = ST_EXEC;
      ST_EXEC: state_d = (mode_q == MODE_CIRCLE) ? ST_CIRC : ST_WAIT;
      ST_CIRC: if (circ.done) state_d = ST_WAIT;
      ST_WAIT: state_d = ST_DONE;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      width_q   <= REG_W'(128);
      height_q  <= REG_W'(64);
    end else begin
      state_q <= state_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_WIDTH:  width_q  <= cfg_data_i;
          CFG_HEIGHT: height_q <= cfg_data_i;
          default:    width_q  <= width_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_beat) begin
      mode_q  <= mode_e'(s_axis_tuser);
      x_q     <= s_axis_tdata[7:0];
      y_q     <= s_axis_tdata[15:8];
      r_q     <= s_axis_tdata[21:16];
      color_q <= s_axis_tdata[22];
      addr_q  <= s_axis_tdata[35:23];
      data_q  <= s_axis_tdata[43:36];
    end
    if (state_q == ST_EXEC) begin
      res_rd_q   <= '0;
      res_drop_q <= (mode_q == MODE_PIXEL) && fb_drop;
      res_bad_q  <= ((mode_q == MODE_WRITE) || (mode_q == MODE_READ)) && fb_bad;
    end
    if (state_q == ST_WAIT && mode_q == MODE_READ && !res_bad_q) begin
      res_rd_q <= fb_rdata;
    end
    if (out_load) begin
      m_data_q <= {6'd0, res_bad_q, res_drop_q, res_rd_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

[hw/rtl/mcx_circle_gen.sv]
// ----------------------------------------------------------------------------
// mcx_circle_gen
// midpoint circle sequencer, emits one outline point per cycle in its INIT and PTS states
// ----------------------------------------------------------------------------
module mcx_circle_gen import mcx_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CRD_W-1:0] cx_i,
  input  logic [CRD_W-1:0] cy_i,
  input  logic [RAD_W-1:0] r_i,
  output circ_out_t        out_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_INIT = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_PTS  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [2:0]       phase_q, phase_d;
  logic [CRD_W-1:0] cx_q, cy_q;
  logic [7:0]       f_q, sx_q, sy_q;
  logic [RAD_W-1:0] dx_q, dy_q;

  logic [RAD_W-1:0] ox, oy;
  logic             negx, negy;
  logic             f_pos, more;
  logic [7:0]       sy_n, f_a, sx_n, f_n;
  logic [RAD_W-1:0] dy_n, dx_n;

  // point offsets per phase
  always_comb begin
    ox   = '0;
    oy   = '0;
    negx = 1'b0;
    negy = 1'b0;
    if (state_q == ST_INIT) begin
      unique case (phase_q[1:0])
        2'd0: oy = dy_q;
        2'd1: begin oy = dy_q; negy = 1'b1; end
        2'd2: ox = dy_q;
        default: begin ox = dy_q; negx = 1'b1; end
      endcase
    end else begin
      unique case (phase_q)
        3'd0: begin ox = dx_q; oy = dy_q; end
        3'd1: begin ox = dx_q; oy = dy_q; negx = 1'b1; end
        3'd2: begin ox = dx_q; oy = dy_q; negy = 1'b1; end
        3'd3: begin ox = dx_q; oy = dy_q; negx = 1'b1; negy = 1'b1; end
        3'd4: begin ox = dy_q; oy = dx_q; end
        3'd5: begin ox = dy_q; oy = dx_q; negx = 1'b1; end
        3'd6: begin ox = dy_q; oy = dx_q; negy = 1'b1; end
        default: begin ox = dy_q; oy = dx_q; negx = 1'b1; negy = 1'b1; end
      endcase
    end
  end

  // decision update
  always_comb begin
    f_pos = ~f_q[7];
    more  = (dx_q < dy_q);
    sy_n  = f_pos ? sy_q + 8'd2 : sy_q;
    f_a   = f_pos ? f_q + sy_n : f_q;
    dy_n  = f_pos ? dy_q - RAD_W'(1) : dy_q;
    sx_n  = sx_q + 8'd2;
    f_n   = f_a + sx_n;
    dx_n  = dx_q + RAD_W'(1);
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_INIT;
          phase_d = '0;
        end
      end
      ST_INIT: begin
        phase_d = phase_q + 3'd1;
        if (phase_q[1:0] == 2'd3) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        phase_d = '0;
        state_d = more ? ST_PTS : ST_IDLE;
      end
      default: begin
        phase_d = phase_q + 3'd1;
        if (phase_q == 3'd7) begin
          state_d = ST_UPD;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      cx_q <= cx_i;
      cy_q <= cy_i;
      f_q  <= 8'd1 - {2'b00, r_i};
      sx_q <= 8'd1;
      sy_q <= 8'd0 - {1'b0, r_i, 1'b0};
      dx_q <= '0;
      dy_q <= r_i;
    end else if (state_q == ST_UPD && more) begin
      f_q  <= f_n;
      sx_q <= sx_n;
      sy_q <= sy_n;
      dx_q <= dx_n;
      dy_q <= dy_n;
    end
  end

  assign out_o.pt_valid = (state_q == ST_INIT) || (state_q == ST_PTS);
  assign out_o.x = negx ? cx_q - {2'b00, ox} : cx_q + {2'b00, ox};
  assign out_o.y = negy ? cy_q - {2'b00, oy} : cy_q + {2'b00, oy};
  assign out_o.done = (state_q == ST_UPD) && !more;

endmodule

[hw/rtl/mcx_fb_rmw.sv]
// ----------------------------------------------------------------------------
// mcx_fb_rmw
// framebuffer memory with a pipelined read-modify-write pixel unit
// ----------------------------------------------------------------------------
module mcx_fb_rmw import mcx_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fb_req_t          req_i,
  input  logic [REG_W-1:0] width_i,
  input  logic [REG_W-1:0] height_i,
  output logic             drop_o,
  output logic             bad_o,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [MEM_BYTES];

  logic [13:0]       row_base;
  logic [FA_W-1:0]   paddr, baddr;
  logic              inb, keep, bad, plot_go;
  logic [MEM_AW-1:0] rd_addr, wa;
  logic [7:0]        wd, base, new_byte;
  logic              we;

  logic              s1_valid_q;
  logic [MEM_AW-1:0] s1_addr_q;
  logic [7:0]        s1_mask_q;
  logic              s1_color_q;
  logic              s1_fwd_q;
  logic [7:0]        fwd_q;
  logic [7:0]        rdata_q;

  always_comb begin
    inb      = ({1'b0, req_i.x} < width_i) && ({1'b0, req_i.y} < height_i);
    row_base = 14'({9'd0, req_i.y[7:3]} * {5'd0, width_i});
    paddr    = FA_W'(row_base) + FA_W'(req_i.x);
    keep     = inb && (paddr < MEM_LIMIT);
    baddr    = FA_W'(req_i.addr);
    bad      = (baddr >= MEM_LIMIT);
    plot_go  = (req_i.kind == REQ_PLOT) && keep;
    rd_addr  = (req_i.kind == REQ_PLOT) ? paddr[MEM_AW-1:0] : baddr[MEM_AW-1:0];
  end

  // write stage of the pixel update, shared with byte writes; a pixel update has priority
  always_comb begin
    base     = s1_fwd_q ? fwd_q : rdata_q;
    new_byte = s1_color_q ? (base ^ s1_mask_q) : (base & ~s1_mask_q);
    we       = s1_valid_q || ((req_i.kind == REQ_WRITE) && !bad);
    wa       = s1_valid_q ? s1_addr_q : baddr[MEM_AW-1:0];
    wd       = s1_valid_q ? new_byte : req_i.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= plot_go;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q  <= paddr[MEM_AW-1:0];
    s1_mask_q  <= 8'd1 << req_i.y[2:0];
    s1_color_q <= req_i.color;
    s1_fwd_q   <= s1_valid_q && (s1_addr_q == rd_addr);
    fwd_q      <= new_byte;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_q <= mem[rd_addr];
  end

  assign drop_o  = !keep;
  assign bad_o   = bad;
  assign rdata_o = rdata_q;

endmodule

[hw/rtl/mcx_checker.sv]
// ----------------------------------------------------------------------------
// mcx_checker
// port-level checks of the circle raster framebuffer
// ----------------------------------------------------------------------------
module mcx_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [47:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        cfg_we_i,
  input logic        cfg_index_i,
  input logic [8:0]  cfg_data_i
);

  // result beat holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // one command in flight
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a command is in flight");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[8] && m_axis_tdata[9]))
    else $error("drop and bad address flagged together");

  a_drop_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tdata[7:0] == 8'd0)
    else $error("read data on a pixel result");

  a_bad_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tdata[7:0] == 8'd0)
    else $error("read data on a bad address");

endmodule

bind midpoint_circle_xor_raster mcx_checker u_mcx_checker (.*);

[test/midpoint_circle_xor_raster_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_circle_xor_raster_tb
// self-checking bench for the circle raster framebuffer
//
// First the low 1024 bytes, the whole frame at the reset size, are loaded
// with byte writes. Then a short directed set covers the edges, and random
// commands run under a series of width and height settings, including zero,
// one, the full range and sizes that overrun memory. A random command that
// would touch a byte never written is drawn again. A framebuffer model built
// into the bench predicts each reply, which is checked field by field. Both
// stream sides stall at random.
// ----------------------------------------------------------------------------
module midpoint_circle_xor_raster_tb;
  import mcx_pkg::*;

  typedef struct packed {
    logic [7:0] read_data;
    logic       pixel_dropped;
    logic       address_bad;
  } reply_t;

  class framebuffer_model;
    logic [7:0]       frame [MEM_BYTES];
    bit               written [MEM_BYTES];
    bit               probing;
    bit               probe_hit;
    logic [REG_W-1:0] width_px;
    logic [REG_W-1:0] height_px;
    reply_t           expected_replies [$];
    int               mismatches;
    int               replies;
    int               mode_count [4];

    function new();
      width_px   = 9'd128;
      height_px  = 9'd64;
      probing    = 1'b0;
      probe_hit  = 1'b0;
      mismatches = 0;
      replies    = 0;
      foreach (mode_count[i]) mode_count[i] = 0;
    endfunction

    function void set_reg(logic idx, logic [REG_W-1:0] value);
      if (idx == CFG_WIDTH) begin
        width_px = value;
      end else begin
        height_px = value;
      end
    endfunction

    // returns 1 when the pixel is dropped
    function bit plot(logic [7:0] x, logic [7:0] y, logic color);
      int unsigned a;
      if (x >= width_px || y >= height_px) return 1'b1;
      a = int'(x) + int'(y >> 3) * int'(width_px);
      if (a >= MEM_BYTES) return 1'b1;
      if (probing) begin
        if (!written[a]) probe_hit = 1'b1;
        return 1'b0;
      end
      if (color) begin
        frame[a][y[2:0]] = ~frame[a][y[2:0]];
      end else begin
        frame[a][y[2:0]] = 1'b0;
      end
      return 1'b0;
    endfunction

    function void circle(logic [7:0] cx, logic [7:0] cy, logic [RAD_W-1:0] r,
                         logic color);
      byte f;
      byte step_x;
      byte step_y;
      int  dx;
      int  dy;
      f      = byte'(1 - int'(r));
      step_x = 1;
      step_y = byte'(-2 * int'(r));
      dx     = 0;
      dy     = int'(r);
      void'(plot(cx, 8'(cy + dy), color));
      void'(plot(cx, 8'(cy - dy), color));
      void'(plot(8'(cx + dy), cy, color));
      void'(plot(8'(cx - dy), cy, color));
      while (dx < dy) begin
        if (f >= 0) begin
          dy--;
          step_y = byte'(step_y + 2);
          f      = byte'(f + step_y);
        end
        dx++;
        step_x = byte'(step_x + 2);
        f      = byte'(f + step_x);
        void'(plot(8'(cx + dx), 8'(cy + dy), color));
        void'(plot(8'(cx - dx), 8'(cy + dy), color));
        void'(plot(8'(cx + dx), 8'(cy - dy), color));
        void'(plot(8'(cx - dx), 8'(cy - dy), color));
        void'(plot(8'(cx + dy), 8'(cy + dx), color));
        void'(plot(8'(cx - dy), 8'(cy + dx), color));
        void'(plot(8'(cx + dy), 8'(cy - dx), color));
        void'(plot(8'(cx - dy), 8'(cy - dx), color));
      end
    endfunction

    // true when the command touches only bytes that were written
    function bit fits(mode_e mode, logic [7:0] x, logic [7:0] y, logic [RAD_W-1:0] r,
                      logic [BADR_W-1:0] addr);
      if (mode == MODE_WRITE) return 1'b1;
      if (mode == MODE_READ) return written[addr];
      probing   = 1'b1;
      probe_hit = 1'b0;
      if (mode == MODE_PIXEL) void'(plot(x, y, 1'b0));
      else circle(x, y, r, 1'b0);
      probing = 1'b0;
      return !probe_hit;
    endfunction

    function void note_command(mode_e mode, logic [7:0] x, logic [7:0] y,
                               logic [RAD_W-1:0] r, logic color,
                               logic [BADR_W-1:0] addr, logic [7:0] data);
      reply_t e;
      e = '0;
      mode_count[mode]++;
      case (mode)
        MODE_PIXEL: begin
          e.pixel_dropped = plot(x, y, color);
        end
        MODE_CIRCLE: begin
          circle(x, y, r, color);
        end
        MODE_WRITE: begin
          if (addr >= MEM_BYTES) e.address_bad = 1'b1;
          else begin
            frame[addr]   = data;
            written[addr] = 1'b1;
          end
        end
        default: begin
          if (addr >= MEM_BYTES) e.address_bad = 1'b1;
          else e.read_data = frame[addr];
        end
      endcase
      expected_replies.push_back(e);
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatches++;
    endtask

    task check_result(logic [15:0] beat);
      reply_t e;
      if (expected_replies.size() == 0) begin
        report_mismatch("unexpected result beat", int'(beat), 0);
        return;
      end
      e = expected_replies.pop_front();
      replies++;
      if (beat[7:0] !== e.read_data)
        report_mismatch("read_data", int'(beat[7:0]), int'(e.read_data));
      if (beat[8] !== e.pixel_dropped)
        report_mismatch("pixel_dropped", int'(beat[8]), int'(e.pixel_dropped));
      if (beat[9] !== e.address_bad)
        report_mismatch("address_bad", int'(beat[9]), int'(e.address_bad));
    endtask
  endclass

  localparam int PHASES = 9;
  localparam int RANDOM_PER_PHASE = 50;
  localparam int LOAD_BYTES = 1024;
  localparam logic [REG_W-1:0] WIDTH_SET [PHASES] =
    '{9'd128, 9'd1, 9'd256, 9'd0, 9'd511, 9'd37, 9'd96, 9'd256, 9'd128};
  localparam logic [REG_W-1:0] HEIGHT_SET [PHASES] =
    '{9'd64, 9'd1, 9'd256, 9'd64, 9'd256, 9'd0, 9'd300, 9'd17, 9'd64};

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [47:0]      s_axis_tdata;  // pos_x, pos_y, radius, color, byte_address, byte_data
  logic [1:0]       s_axis_tuser;  // mode
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [15:0]      m_axis_tdata;  // read_data, pixel_dropped, address_bad
  logic             cfg_we_i;
  logic             cfg_index_i;
  logic [REG_W-1:0] cfg_data_i;

  framebuffer_model model = new();
  bit               quiet = 1'b0;
  int               stall_left = 0;

  midpoint_circle_xor_raster dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int gap_cycles();
    int p;
    if (quiet) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] coord(logic [REG_W-1:0] limit);
    if (limit == 0 || $urandom_range(0, 3) == 0) return 8'($urandom);
    return 8'($urandom_range(0, (limit > 256 ? 256 : int'(limit)) - 1));
  endfunction

  // result side: random stalls, every accepted beat is checked
  always @(posedge clk_i) begin
    int g;
    if (rst_ni && m_axis_tvalid && m_axis_tready) model.check_result(m_axis_tdata);
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      g = gap_cycles();
      stall_left    <= g;
      m_axis_tready <= (g == 0);
    end
  end

  task automatic send_command(mode_e mode, logic [7:0] x, logic [7:0] y,
                              logic [RAD_W-1:0] r, logic color,
                              logic [BADR_W-1:0] addr, logic [7:0] data);
    int gap;
    gap = gap_cycles();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {4'b0, data, addr, color, r, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    model.note_command(mode, x, y, r, color, addr, data);
  endtask

  // sender holds off until every reply is back, then lets the block settle
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (model.expected_replies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_register(logic idx, logic [REG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    model.set_reg(idx, value);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_command();
    int                p;
    int                tries;
    mode_e             m;
    logic [RAD_W-1:0]  r;
    logic [BADR_W-1:0] addr;
    logic [7:0]        x;
    logic [7:0]        y;
    tries = 0;
    do begin
      p = $urandom_range(0, 99);
      m = p < 35 ? MODE_PIXEL : p < 50 ? MODE_CIRCLE : p < 75 ? MODE_WRITE : MODE_READ;
      r = ($urandom_range(0, 9) == 0) ? RAD_W'($urandom_range(0, 63))
                                      : RAD_W'($urandom_range(0, 12));
      addr = $urandom_range(0, 1) ? BADR_W'($urandom_range(0, 2047)) : BADR_W'($urandom);
      x = coord(model.width_px);
      y = coord(model.height_px);
      tries++;
    end while (!model.fits(m, x, y, r, addr) && tries < 100);
    // nothing usable found, fall back to a byte write
    if (!model.fits(m, x, y, r, addr)) m = MODE_WRITE;
    send_command(m, x, y, r, 1'($urandom), addr, 8'($urandom));
  endtask

  initial begin
    int n;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= MODE_PIXEL;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= CFG_WIDTH;
    cfg_data_i    <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // load the whole reset-size frame
    for (int a = 0; a < LOAD_BYTES; a++)
      send_command(MODE_WRITE, 8'($urandom), 8'($urandom), RAD_W'($urandom), 1'($urandom),
                   BADR_W'(a), 8'($urandom));
    drain_results();

    // directed edges under the reset size of 128 x 64
    send_command(MODE_PIXEL,  8'd0,   8'd0,   6'd0,  1'b1, 13'd0,    8'h00);
    send_command(MODE_PIXEL,  8'd127, 8'd63,  6'd63, 1'b1, 13'h1fff, 8'hff);
    send_command(MODE_PIXEL,  8'd128, 8'd0,   6'd0,  1'b1, 13'd0,    8'h00);
    send_command(MODE_PIXEL,  8'd0,   8'd64,  6'd0,  1'b1, 13'd0,    8'h00);
    send_command(MODE_PIXEL,  8'd255, 8'd255, 6'd0,  1'b0, 13'd0,    8'h00);
    send_command(MODE_PIXEL,  8'd5,   8'd5,   6'd0,  1'b0, 13'd0,    8'h00);
    send_command(MODE_READ,   8'd0,   8'd0,   6'd0,  1'b0, 13'd0,    8'h00);
    send_command(MODE_READ,   8'd0,   8'd0,   6'd0,  1'b0, 13'd1023, 8'h00);
    send_command(MODE_READ,   8'd0,   8'd0,   6'd0,  1'b0, 13'd5,    8'h00);
    send_command(MODE_WRITE,  8'd0,   8'd0,   6'd0,  1'b0, 13'd0,    8'hff);
    send_command(MODE_WRITE,  8'd0,   8'd0,   6'd0,  1'b0, 13'h1fff, 8'h00);
    send_command(MODE_WRITE,  8'd0,   8'd0,   6'd0,  1'b0, 13'd4096, 8'ha5);
    send_command(MODE_READ,   8'd0,   8'd0,   6'd0,  1'b0, 13'd0,    8'h00);
    send_command(MODE_READ,   8'd0,   8'd0,   6'd0,  1'b0, 13'h1fff, 8'h00);
    send_command(MODE_READ,   8'd0,   8'd0,   6'd0,  1'b0, 13'd4096, 8'h00);
    // zero radius: xor leaves the center, clear clears it
    send_command(MODE_CIRCLE, 8'd20,  8'd20,  6'd0,  1'b1, 13'd0,    8'h00);
    send_command(MODE_READ,   8'd0,   8'd0,   6'd0,  1'b0, 13'd276,  8'h00);
    send_command(MODE_CIRCLE, 8'd20,  8'd20,  6'd0,  1'b0, 13'd0,    8'h00);
    send_command(MODE_READ,   8'd0,   8'd0,   6'd0,  1'b0, 13'd276,  8'h00);
    // largest radius, centered and wrapping around the origin, then a radius-1 clear that wraps
    send_command(MODE_CIRCLE, 8'd64,  8'd32,  6'd63, 1'b1, 13'd0,    8'h00);
    send_command(MODE_CIRCLE, 8'd0,   8'd0,   6'd63, 1'b1, 13'd0,    8'h00);
    send_command(MODE_CIRCLE, 8'd255, 8'd255, 6'd1,  1'b0, 13'd0,    8'h00);
    send_command(MODE_READ,   8'd0,   8'd0,   6'd0,  1'b0, 13'd63,   8'h00);
    send_command(MODE_READ,   8'd0,   8'd0,   6'd0,  1'b0, 13'd384,  8'h00);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        drain_results();
        if (WIDTH_SET[ph] != model.width_px) write_register(CFG_WIDTH, WIDTH_SET[ph]);
        if (HEIGHT_SET[ph] != model.height_px) write_register(CFG_HEIGHT, HEIGHT_SET[ph]);
      end
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % 25 == 0) quiet = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) < 2) drain_results();
        random_command();
      end
    end
    quiet = 1'b0;
    drain_results();
    repeat (20) @(posedge clk_i);

    $display("run covered %0d pixel, %0d circle, %0d byte write and %0d byte read commands",
             model.mode_count[MODE_PIXEL], model.mode_count[MODE_CIRCLE],
             model.mode_count[MODE_WRITE], model.mode_count[MODE_READ]);
    $display("%0d replies checked over %0d width and height settings, %0d mismatches",
             model.replies, PHASES, model.mismatches);
    if (model.mismatches == 0 && model.expected_replies.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/mcx_pkg.sv
hw/rtl/mcx_circle_gen.sv
hw/rtl/mcx_fb_rmw.sv
hw/rtl/midpoint_circle_xor_raster.sv
hw/rtl/mcx_checker.sv
test/midpoint_circle_xor_raster_tb.sv
